FILE: hw/rtl/kvtc_pkg.sv
// kvtc_pkg: shared types and codes for the key-value table with compaction
// used by kvtc_cell and key_value_table_with_compaction; no dependencies
package kvtc_pkg;

    localparam int KEY_W      = 64;
    localparam int IN_VALUE_W = 32;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_UPDATE = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } status_t;

    // per-cycle commands broadcast from the controller to every cell
    typedef struct packed {
        logic capture;    // register the key compare of a new transaction
        logic ins_wr;     // append at the slot that equals the fill count
        logic upd_wr;     // overwrite the value of the matching cell
        logic del_shift;  // cells at or above the match take their upper neighbor
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/kvtc_cell.sv
// kvtc_cell: one slot of the table with its key compare, hit chain and shift
// depends on kvtc_pkg
module kvtc_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 7,
    parameter int IDX         = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kvtc_pkg::cell_ctrl_t      ctrl,
    input  logic [kvtc_pkg::KEY_W-1:0] req_key,
    input  logic [kvtc_pkg::KEY_W-1:0] cap_key,
    input  logic [VALUE_WIDTH-1:0]    req_value,
    input  logic [CW-1:0]             count,
    input  logic [kvtc_pkg::KEY_W-1:0] nbr_key,
    input  logic [VALUE_WIDTH-1:0]    nbr_value,
    input  logic                      hit_in,
    input  logic [VALUE_WIDTH-1:0]    hit_val_in,
    output logic [kvtc_pkg::KEY_W-1:0] cell_key,
    output logic [VALUE_WIDTH-1:0]    cell_value,
    output logic                      hit_out,
    output logic [VALUE_WIDTH-1:0]    hit_val_out
);
    import kvtc_pkg::*;

    logic [KEY_W-1:0]       key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   match_reg;
    logic                   filled;

    assign filled      = CW'(IDX) < count;
    assign hit_out     = hit_in | match_reg;
    assign hit_val_out = hit_val_in | (match_reg ? value_reg : '0);
    assign cell_key    = key_reg;
    assign cell_value  = value_reg;

    // only filled slots compare, so stale contents above the fill count never hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= filled && (key_reg == cap_key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_wr && (count == CW'(IDX)))
        begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
        else if (ctrl.upd_wr && match_reg)
        begin
            value_reg <= req_value;
        end
        else if (ctrl.del_shift && hit_out)
        begin
            key_reg   <= nbr_key;
            value_reg <= nbr_value;
        end
    end

endmodule

FILE: hw/rtl/key_value_table_with_compaction.sv
// key_value_table_with_compaction: top level, a row of kvtc_cell slots and the controller
// depends on kvtc_pkg and kvtc_cell
// result: compare registered on accept, then resolve/commit once the output register is free
// one transaction at a time: in_ready is low until the result is committed; set by the
//   registered compare in every cell followed by the hit chain through the row of cells
// reset: asynchronous active low; clears fill count, controller and output valid,
//   slot contents are left as they are and are never read before being written
module key_value_table_with_compaction #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [kvtc_pkg::REQ_W-1:0]       req_type,
    input  logic [kvtc_pkg::KEY_W-1:0]       key,
    input  logic [kvtc_pkg::IN_VALUE_W-1:0]  entry_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [kvtc_pkg::STATUS_W-1:0]    status,
    output logic [kvtc_pkg::IN_VALUE_W-1:0]  found_value,
    output logic [kvtc_pkg::FILL_W-1:0]      fill_count
);
    import kvtc_pkg::*;

    // fill count must reach DEPTH itself
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [IN_VALUE_W-1:0]   found_reg, found_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;

    // held request of the transaction in flight
    req_type_t               op_type_reg;
    logic [KEY_W-1:0]        op_key_reg;
    logic [VALUE_WIDTH-1:0]  op_value_reg;

    // row of cells: neighbor data goes down, the hit chain goes up
    logic [KEY_W-1:0]        key_w   [DEPTH];
    logic [VALUE_WIDTH-1:0]  val_w   [DEPTH];
    logic                    hit_w   [DEPTH+1];
    logic [VALUE_WIDTH-1:0]  hval_w  [DEPTH+1];

    cell_ctrl_t              ctrl;
    logic                    accept;
    logic                    commit;
    logic                    hit;
    logic [VALUE_WIDTH-1:0]  hit_value;
    logic                    key_zero;
    logic                    full;
    logic                    ins_ok;

    assign hit_w[0]  = 1'b0;
    assign hval_w[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0]       nbr_key;
            logic [VALUE_WIDTH-1:0] nbr_value;

            // the top slot keeps its own contents on a delete, it falls out of the fill count
            if (gi == DEPTH - 1)
            begin : g_top
                assign nbr_key   = key_w[gi];
                assign nbr_value = val_w[gi];
            end
            else
            begin : g_mid
                assign nbr_key   = key_w[gi+1];
                assign nbr_value = val_w[gi+1];
            end

            kvtc_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .CW          (CW),
                .IDX         (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .req_key     (op_key_reg),
                .cap_key     (key),
                .req_value   (op_value_reg),
                .count       (count_reg),
                .nbr_key     (nbr_key),
                .nbr_value   (nbr_value),
                .hit_in      (hit_w[gi]),
                .hit_val_in  (hval_w[gi]),
                .cell_key    (key_w[gi]),
                .cell_value  (val_w[gi]),
                .hit_out     (hit_w[gi+1]),
                .hit_val_out (hval_w[gi+1])
            );
        end
    endgenerate

    // filled keys are unique, so at most one cell matches and the chain needs no priority
    assign hit       = hit_w[DEPTH];
    assign hit_value = hval_w[DEPTH];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    // a result may only be written once the output register is free
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign key_zero  = (op_key_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    // duplicate check ranks ahead of the full check
    assign ins_ok    = (op_type_reg == REQ_INSERT) && !key_zero && !hit && !full;

    always_comb
    begin
        ctrl.capture   = accept;
        ctrl.ins_wr    = commit && ins_ok;
        ctrl.upd_wr    = commit && (op_type_reg == REQ_UPDATE) && hit;
        ctrl.del_shift = commit && (op_type_reg == REQ_DELETE) && hit;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.del_shift)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // result of the transaction in flight
    always_comb
    begin
        found_next = '0;
        unique case (op_type_reg)
            REQ_INSERT:
            begin
                priority if (key_zero)
                begin
                    status_next = ST_ZERO_KEY;
                end
                else if (hit)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                end
            end
            REQ_LOOKUP:
            begin
                status_next = hit ? ST_OK : ST_NOT_FOUND;
                found_next  = hit ? IN_VALUE_W'(hit_value) : '0;
            end
            REQ_DELETE, REQ_UPDATE:
            begin
                status_next = hit ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        fill_next      = fill_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    fill_next      = FILL_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            found_reg     <= '0;
            fill_reg      <= '0;
            op_type_reg   <= REQ_INSERT;
            op_key_reg    <= '0;
            op_value_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                status_reg <= status_next;
                found_reg  <= found_next;
            end
            fill_reg <= fill_next;
            if (accept)
            begin
                op_type_reg  <= req_type_t'(req_type);
                op_key_reg   <= key;
                op_value_reg <= VALUE_WIDTH'(entry_value);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign fill_count  = fill_reg;

`ifndef ASSERT_OFF
    // fill count never runs past the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above table size");

    // a successful insert grows the table by exactly one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_wr |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance fill count");

    // a returned value only accompanies a successful lookup
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (found_reg != '0)) |-> (status_reg == ST_OK))
        else $error("nonzero found value with failing status");

    // a new transaction is never taken while one is still being resolved
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !ctrl.capture)
        else $error("transaction accepted during execution");
`endif

endmodule
